// ===== hw/rtl/brc_pkg.sv =====
// Package: shared types, codes and constants of the branch rate classifier.
package brc_pkg;

  localparam int PC_W  = 48;
  localparam int VAL_W = 48;
  localparam int HYB_W = 11;
  localparam int BIN_W = 5;
  localparam int SEL_W = 3;

  typedef enum logic [1:0] {
    CMD_EVENT    = 2'd0,
    CMD_CLASSIFY = 2'd1,
    CMD_READ     = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic [SEL_W-1:0] {
    RSEL_HYB_CNT = 3'd0,
    RSEL_TKN_CNT = 3'd1,
    RSEL_TRN_CNT = 3'd2,
    RSEL_HYB_EX  = 3'd3,
    RSEL_TKN_EX  = 3'd4,
    RSEL_TRN_EX  = 3'd5,
    RSEL_TOTAL   = 3'd6
  } rsel_e;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_SCAN_ADDR,
    S_SCAN_CMP,
    S_EVT_WR,
    S_CLS_CLR,
    S_WALK_ADDR,
    S_WALK_DATA,
    S_DIV,
    S_HIST_RD,
    S_HIST_WR,
    S_READ_ADDR,
    S_READ_DATA,
    S_DONE
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic clr_step;
    logic scan_rd;
    logic scan_cmp;
    logic scan_inc;
    logic evt_wr;
    logic walk_ld;
    logic div_step;
    logic hist_rd;
    logic hist_wr;
    logic rd_issue;
    logic rd_cap;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    cmd_e in_cmd;
    logic scan_end;
    logic pc_match;
    logic clr_done;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/brc_in_if.sv =====
// Interface: input channel carrying event, classify and read transactions.
interface brc_in_if import brc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic [PC_W-1:0]  branch_pc;
  logic             outcome_taken;
  logic [SEL_W-1:0] read_select;
  logic [BIN_W-1:0] row_bin;
  logic [BIN_W-1:0] col_bin;

  modport source (output valid, command, branch_pc, outcome_taken, read_select, row_bin,
                  col_bin, input ready);
  modport sink (input valid, command, branch_pc, outcome_taken, read_select, row_bin,
                col_bin, output ready);
endinterface

// ===== hw/rtl/brc_out_if.sv =====
// Interface: result channel carrying read value and drop flag.
interface brc_out_if import brc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] read_value;
  logic             dropped;

  modport source (output valid, read_value, dropped, input ready);
  modport sink (input valid, read_value, dropped, output ready);
endinterface

// ===== hw/rtl/branch_rate_classifier_top.sv =====
// Top level: branch rate classifier, controller plus datapath.
//
// Input channel evt_i carries one transaction per command: a branch event
// (PC and outcome), a classify request, a read of a histogram cell or the
// total, or a no-op. Each input transaction yields exactly one transaction on
// res_o carrying read_value (zero unless a read) and dropped (set when an
// event's new PC found the table full).
// An event compares the valid table entries one at a time and ends on a
// hit, an allocation or a drop. Classify clears the histograms, then runs
// the bin divider and histogram read-modify-write for each valid entry.
// One transaction is in flight at a time.
// Reset: the table empties at once (fill count), and a clearing pass zeroes
// all RATE_BINS^2 histogram cells before evt_i goes ready.
// Stall: the result sits in an output register; the next transaction is
// accepted meanwhile and its result waits until res_o drains.
module branch_rate_classifier_top import brc_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int RATE_BINS     = 20,
  parameter int COUNT_BITS    = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  brc_in_if.sink   evt_i,
  brc_out_if.source res_o
);

  ctrl_t ctrl;
  stat_t stat;

  brc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (evt_i.valid),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  brc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .RATE_BINS     (RATE_BINS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .command_i       (evt_i.command),
    .branch_pc_i     (evt_i.branch_pc),
    .outcome_taken_i (evt_i.outcome_taken),
    .read_select_i   (evt_i.read_select),
    .row_bin_i       (evt_i.row_bin),
    .col_bin_i       (evt_i.col_bin),
    .res_ready_i     (res_o.ready),
    .res_valid_o     (res_o.valid),
    .read_value_o    (res_o.read_value),
    .dropped_o       (res_o.dropped)
  );

  assign evt_i.ready = ctrl.in_ready;

endmodule

// ===== hw/rtl/brc_ctrl.sv =====
// Controller: sequencer state machine of the branch rate classifier.
module brc_ctrl import brc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT_CLR: if (stat_i.clr_done) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (stat_i.in_cmd)
            CMD_EVENT:    state_d = S_SCAN_ADDR;
            CMD_CLASSIFY: state_d = S_CLS_CLR;
            CMD_READ:     state_d = S_READ_ADDR;
            default:      state_d = S_DONE;
          endcase
        end
      end
      S_SCAN_ADDR: state_d = stat_i.scan_end ? S_EVT_WR : S_SCAN_CMP;
      S_SCAN_CMP:  state_d = stat_i.pc_match ? S_EVT_WR : S_SCAN_ADDR;
      S_EVT_WR:    state_d = S_DONE;
      S_CLS_CLR:   if (stat_i.clr_done) state_d = S_WALK_ADDR;
      S_WALK_ADDR: state_d = stat_i.scan_end ? S_DONE : S_WALK_DATA;
      S_WALK_DATA: state_d = S_DIV;
      S_DIV:       if (stat_i.div_done) state_d = S_HIST_RD;
      S_HIST_RD:   state_d = S_HIST_WR;
      S_HIST_WR:   state_d = S_WALK_ADDR;
      S_READ_ADDR: state_d = S_READ_DATA;
      S_READ_DATA: state_d = S_DONE;
      S_DONE:      if (stat_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      S_INIT_CLR:  ctrl_o.clr_step = 1'b1;
      S_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.load_in  = in_valid_i;
      end
      S_SCAN_ADDR: ctrl_o.scan_rd = !stat_i.scan_end;
      S_SCAN_CMP: begin
        ctrl_o.scan_cmp = 1'b1;
        ctrl_o.scan_inc = !stat_i.pc_match;
      end
      S_EVT_WR:    ctrl_o.evt_wr = 1'b1;
      S_CLS_CLR:   ctrl_o.clr_step = 1'b1;
      S_WALK_ADDR: ctrl_o.scan_rd = !stat_i.scan_end;
      S_WALK_DATA: ctrl_o.walk_ld = 1'b1;
      S_DIV:       ctrl_o.div_step = 1'b1;
      S_HIST_RD:   ctrl_o.hist_rd = 1'b1;
      S_HIST_WR: begin
        ctrl_o.hist_wr  = 1'b1;
        ctrl_o.scan_inc = 1'b1;
      end
      S_READ_ADDR: ctrl_o.rd_issue = 1'b1;
      S_READ_DATA: ctrl_o.rd_cap = 1'b1;
      S_DONE:      ctrl_o.out_load = stat_i.out_free;
      default:     ctrl_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/brc_datapath.sv =====
// Datapath: branch table, rate divider, histogram memories and result register.
module brc_datapath import brc_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int RATE_BINS     = 20,
  parameter int COUNT_BITS    = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  output stat_t            stat_o,
  input  logic [1:0]       command_i,
  input  logic [PC_W-1:0]  branch_pc_i,
  input  logic             outcome_taken_i,
  input  logic [SEL_W-1:0] read_select_i,
  input  logic [BIN_W-1:0] row_bin_i,
  input  logic [BIN_W-1:0] col_bin_i,
  input  logic             res_ready_i,
  output logic             res_valid_o,
  output logic [VAL_W-1:0] read_value_o,
  output logic             dropped_o
);

  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int FW  = $clog2(TABLE_ENTRIES + 1);
  localparam int BW  = $clog2(RATE_BINS);
  localparam int CELLS = RATE_BINS * RATE_BINS;
  localparam int CW  = $clog2(CELLS);
  localparam int QB  = $clog2(RATE_BINS + 1);
  localparam int SW  = $clog2(QB);
  localparam int EXW = (COUNT_BITS + 1 > VAL_W) ? VAL_W : COUNT_BITS + 1;
  localparam int NW  = COUNT_BITS + QB;
  localparam int DW  = EXW + QB;
  localparam int CB  = COUNT_BITS;

  function automatic logic [CB-1:0] cnt_inc(input logic [CB-1:0] x);
    cnt_inc = (&x) ? x : x + 1'b1;
  endfunction

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[VAL_W] ? {VAL_W{1'b1}} : s[VAL_W-1:0];
  endfunction

  // latched transaction
  logic [PC_W-1:0]  pc_q;
  logic             tkn_q;
  logic [SEL_W-1:0] sel_q;
  logic [BIN_W-1:0] row_q, col_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      pc_q  <= branch_pc_i;
      tkn_q <= outcome_taken_i;
      sel_q <= read_select_i;
      row_q <= row_bin_i;
      col_q <= col_bin_i;
    end
  end

  // table control
  logic [FW-1:0] fill_q, scan_q;
  logic [CW-1:0] clr_q;
  logic          hit_q;
  logic [IW-1:0] taddr;
  logic          tbl_full, tbl_we;

  assign taddr    = scan_q[IW-1:0];
  assign tbl_full = (scan_q == FW'(TABLE_ENTRIES));
  assign tbl_we   = ctrl_i.evt_wr && (hit_q || !tbl_full);

  // branch table
  logic [PC_W-1:0] pc_mem [TABLE_ENTRIES];
  logic [CB-1:0]   tk_mem [TABLE_ENTRIES];
  logic [CB-1:0]   nt_mem [TABLE_ENTRIES];
  logic [CB-1:0]   tr_mem [TABLE_ENTRIES];
  logic            lo_mem [TABLE_ENTRIES];
  logic [PC_W-1:0] pc_rd;
  logic [CB-1:0]   tk_rd, nt_rd, tr_rd;
  logic            lo_rd;
  logic [CB-1:0]   tk_wd, nt_wd, tr_wd;

  always_comb begin
    if (hit_q) begin
      tr_wd = (lo_rd != tkn_q) ? cnt_inc(tr_rd) : tr_rd;
      tk_wd = tkn_q ? cnt_inc(tk_rd) : tk_rd;
      nt_wd = tkn_q ? nt_rd : cnt_inc(nt_rd);
    end else begin
      tr_wd = '0;
      tk_wd = CB'(tkn_q);
      nt_wd = CB'(!tkn_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      pc_mem[taddr] <= pc_q;
      tk_mem[taddr] <= tk_wd;
      nt_mem[taddr] <= nt_wd;
      tr_mem[taddr] <= tr_wd;
      lo_mem[taddr] <= tkn_q;
    end
    if (ctrl_i.scan_rd) begin
      pc_rd <= pc_mem[taddr];
      tk_rd <= tk_mem[taddr];
      nt_rd <= nt_mem[taddr];
      tr_rd <= tr_mem[taddr];
      lo_rd <= lo_mem[taddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      scan_q <= '0;
      clr_q  <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (ctrl_i.load_in) begin
        scan_q <= '0;
        clr_q  <= '0;
        hit_q  <= 1'b0;
      end else begin
        if (ctrl_i.scan_inc) scan_q <= scan_q + 1'b1;
        if (ctrl_i.clr_step) clr_q <= clr_q + 1'b1;
        if (ctrl_i.scan_cmp && pc_rd == pc_q) hit_q <= 1'b1;
      end
      if (ctrl_i.evt_wr && !hit_q && !tbl_full) fill_q <= fill_q + 1'b1;
    end
  end

  // rate divider, two restoring lanes, one quotient bit per step
  logic [EXW-1:0] ex_q;
  logic [NW-1:0]  rem_t_q, rem_r_q;
  logic [DW-1:0]  dv_q;
  logic [QB-1:0]  q_t_q, q_r_q;
  logic [SW-1:0]  step_q;
  logic [VAL_W:0] ex_sum;
  logic [VAL_W:0] ex_sat;
  logic           ge_t, ge_r;

  assign ex_sum = (VAL_W+1)'(tk_rd) + (VAL_W+1)'(nt_rd);
  assign ex_sat = ex_sum[VAL_W] ? {1'b0, {VAL_W{1'b1}}} : ex_sum;
  assign ge_t   = DW'(rem_t_q) >= dv_q;
  assign ge_r   = DW'(rem_r_q) >= dv_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.walk_ld) begin
      ex_q    <= ex_sat[EXW-1:0];
      rem_t_q <= NW'(tk_rd) * NW'(RATE_BINS);
      rem_r_q <= NW'(tr_rd) * NW'(RATE_BINS);
      dv_q    <= DW'(ex_sat[EXW-1:0]) << (QB - 1);
      q_t_q   <= '0;
      q_r_q   <= '0;
      step_q  <= SW'(QB - 1);
    end else if (ctrl_i.div_step) begin
      if (ge_t) rem_t_q <= NW'(DW'(rem_t_q) - dv_q);
      if (ge_r) rem_r_q <= NW'(DW'(rem_r_q) - dv_q);
      q_t_q  <= {q_t_q[QB-2:0], ge_t};
      q_r_q  <= {q_r_q[QB-2:0], ge_r};
      dv_q   <= dv_q >> 1;
      step_q <= step_q - 1'b1;
    end
  end

  logic [BW-1:0] tb, rb;
  logic [CW-1:0] walk_cell, rd_cell;

  assign tb = (ex_q == '0) ? '0 :
              (q_t_q > QB'(RATE_BINS - 1)) ? BW'(RATE_BINS - 1) : q_t_q[BW-1:0];
  assign rb = (ex_q == '0) ? '0 :
              (q_r_q > QB'(RATE_BINS - 1)) ? BW'(RATE_BINS - 1) : q_r_q[BW-1:0];
  assign walk_cell = CW'(int'(rb) * RATE_BINS + int'(tb));
  assign rd_cell   = CW'(int'(row_q) * RATE_BINS + int'(col_q));

  // histogram memories
  logic [HYB_W-1:0] hc_mem [CELLS];
  logic [VAL_W-1:0] hx_mem [CELLS];
  logic [VAL_W-1:0] tc_mem [RATE_BINS];
  logic [VAL_W-1:0] tx_mem [RATE_BINS];
  logic [VAL_W-1:0] rc_mem [RATE_BINS];
  logic [VAL_W-1:0] rx_mem [RATE_BINS];
  logic [HYB_W-1:0] hc_rd;
  logic [VAL_W-1:0] hx_rd, tc_rd, tx_rd, rc_rd, rx_rd;
  logic             h_re, h_we, b_we;
  logic [CW-1:0]    h_ra, h_wa;
  logic [BW-1:0]    t_ra, r_ra, t_wa, r_wa;
  logic [VAL_W-1:0] ex48;

  assign ex48 = VAL_W'(ex_q);
  assign h_re = ctrl_i.hist_rd || ctrl_i.rd_issue;
  assign h_ra = ctrl_i.rd_issue ? rd_cell : walk_cell;
  assign t_ra = ctrl_i.rd_issue ? BW'(row_q) : tb;
  assign r_ra = ctrl_i.rd_issue ? BW'(row_q) : rb;
  assign h_we = ctrl_i.clr_step || ctrl_i.hist_wr;
  assign b_we = (ctrl_i.clr_step && int'(clr_q) < RATE_BINS) || ctrl_i.hist_wr;
  assign h_wa = ctrl_i.clr_step ? clr_q : walk_cell;
  assign t_wa = ctrl_i.clr_step ? BW'(clr_q) : tb;
  assign r_wa = ctrl_i.clr_step ? BW'(clr_q) : rb;

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hc_mem[h_wa] <= ctrl_i.clr_step ? '0 : ((&hc_rd) ? hc_rd : hc_rd + 1'b1);
      hx_mem[h_wa] <= ctrl_i.clr_step ? '0 : sat_add(hx_rd, ex48);
    end
    if (b_we) begin
      tc_mem[t_wa] <= ctrl_i.clr_step ? '0 : sat_add(tc_rd, VAL_W'(1));
      tx_mem[t_wa] <= ctrl_i.clr_step ? '0 : sat_add(tx_rd, ex48);
      rc_mem[r_wa] <= ctrl_i.clr_step ? '0 : sat_add(rc_rd, VAL_W'(1));
      rx_mem[r_wa] <= ctrl_i.clr_step ? '0 : sat_add(rx_rd, ex48);
    end
    if (h_re) begin
      hc_rd <= hc_mem[h_ra];
      hx_rd <= hx_mem[h_ra];
      tc_rd <= tc_mem[t_ra];
      tx_rd <= tx_mem[t_ra];
      rc_rd <= rc_mem[r_ra];
      rx_rd <= rx_mem[r_ra];
    end
  end

  logic [VAL_W-1:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (ctrl_i.clr_step && clr_q == '0) begin
      total_q <= '0;
    end else if (ctrl_i.hist_wr) begin
      total_q <= sat_add(total_q, ex48);
    end
  end

  // read selection
  logic             row_ok, col_ok;
  logic [VAL_W-1:0] rd_val;

  assign row_ok = int'(row_q) < RATE_BINS;
  assign col_ok = int'(col_q) < RATE_BINS;

  always_comb begin
    unique case (rsel_e'(sel_q))
      RSEL_TOTAL:   rd_val = total_q;
      RSEL_HYB_CNT: rd_val = (row_ok && col_ok) ? VAL_W'(hc_rd) : '0;
      RSEL_HYB_EX:  rd_val = (row_ok && col_ok) ? hx_rd : '0;
      RSEL_TKN_CNT: rd_val = row_ok ? tc_rd : '0;
      RSEL_TKN_EX:  rd_val = row_ok ? tx_rd : '0;
      RSEL_TRN_CNT: rd_val = row_ok ? rc_rd : '0;
      RSEL_TRN_EX:  rd_val = row_ok ? rx_rd : '0;
      default:      rd_val = '0;
    endcase
  end

  // result staging and output register
  logic [VAL_W-1:0] res_val_q, out_val_q;
  logic             res_drop_q, out_drop_q, out_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      res_val_q  <= '0;
      res_drop_q <= 1'b0;
    end else begin
      if (ctrl_i.rd_cap) res_val_q <= rd_val;
      if (ctrl_i.evt_wr) res_drop_q <= !hit_q && tbl_full;
    end
    if (ctrl_i.out_load) begin
      out_val_q  <= res_val_q;
      out_drop_q <= res_drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign read_value_o = out_val_q;
  assign dropped_o    = out_drop_q;

  assign stat_o.in_cmd   = cmd_e'(command_i);
  assign stat_o.scan_end = (scan_q == fill_q);
  assign stat_o.pc_match = (pc_rd == pc_q);
  assign stat_o.clr_done = (clr_q == CW'(CELLS - 1));
  assign stat_o.div_done = (step_q == '0);
  assign stat_o.out_free = !out_valid_q || res_ready_i;

endmodule

// ===== tb/brc_tb_if.sv =====
// Testbench channel interfaces are those of the RTL; this file holds the shared stimulus and result types.
package brc_tb_pkg;
  import brc_pkg::*;

  typedef struct {
    cmd_e             cmd;
    logic [PC_W-1:0]  pc;
    logic             taken;
    logic [SEL_W-1:0] sel;
    logic [BIN_W-1:0] row;
    logic [BIN_W-1:0] col;
  } brc_txn_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             dropped;
  } brc_res_t;
endpackage

// ===== tb/tb_top.sv =====
// Testbench top: directed and random transactions against a behavioral profile table.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import brc_pkg::*;
  import brc_tb_pkg::*;

  localparam int N_ENT   = 1024;
  localparam int N_BINS  = 20;
  localparam longint CNT_MAX = 64'hFFFF_FFFF;
  localparam longint VMAX    = 64'hFFFF_FFFF_FFFF;
  localparam longint HMAX    = 2047;
  localparam longint LIMIT   = 3_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  brc_in_if  evt_if ();
  brc_out_if res_if ();

  branch_rate_classifier_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt_if.sink),
    .res_o (res_if.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Behavioral table
  bit          tbl_valid [N_ENT];
  logic [47:0] tbl_pc [N_ENT];
  longint      tbl_tkn [N_ENT];
  longint      tbl_ntk [N_ENT];
  longint      tbl_trn [N_ENT];
  bit          tbl_last [N_ENT];
  longint      hyb_cnt [N_BINS*N_BINS];
  longint      hyb_ex [N_BINS*N_BINS];
  longint      tkn_hist [2*N_BINS];
  longint      trn_hist [2*N_BINS];
  longint      total_ex;

  brc_res_t expected_q[$];
  int       n_err = 0;
  longint   cycles = 0;
  bit       stall_en = 1'b1;
  bit       hold_rx = 1'b0;
  bit       gaps_on = 1'b1;
  logic [47:0] pc_pool [16];

  function automatic longint sat(longint a, longint b, longint m);
    return (a + b > m) ? m : a + b;
  endfunction

  function automatic int rate_bin(longint num, longint den);
    longint q;
    if (den == 0) return 0;
    q = (N_BINS * num) / den;
    return (q > N_BINS - 1) ? N_BINS - 1 : int'(q);
  endfunction

  function automatic bit apply_event(logic [47:0] pc, bit tk);
    int hit, fr;
    hit = -1;
    fr = -1;
    for (int i = 0; i < N_ENT; i++) begin
      if (tbl_valid[i]) begin
        if (tbl_pc[i] == pc && hit < 0) hit = i;
      end else if (fr < 0) begin
        fr = i;
      end
    end
    if (hit < 0) begin
      if (fr < 0) return 1'b1;
      hit = fr;
      tbl_valid[hit] = 1'b1;
      tbl_pc[hit] = pc;
      tbl_tkn[hit] = 0;
      tbl_ntk[hit] = 0;
      tbl_trn[hit] = 0;
      tbl_last[hit] = tk;
    end else if (tbl_last[hit] != tk) begin
      tbl_trn[hit] = sat(tbl_trn[hit], 1, CNT_MAX);
    end
    if (tk) tbl_tkn[hit] = sat(tbl_tkn[hit], 1, CNT_MAX);
    else tbl_ntk[hit] = sat(tbl_ntk[hit], 1, CNT_MAX);
    tbl_last[hit] = tk;
    return 1'b0;
  endfunction

  function automatic void rebuild_histograms();
    longint ex;
    int tb, rb, c;
    foreach (hyb_cnt[i]) begin
      hyb_cnt[i] = 0;
      hyb_ex[i] = 0;
    end
    foreach (tkn_hist[i]) begin
      tkn_hist[i] = 0;
      trn_hist[i] = 0;
    end
    total_ex = 0;
    for (int i = 0; i < N_ENT; i++) begin
      if (!tbl_valid[i]) continue;
      ex = sat(tbl_tkn[i], tbl_ntk[i], VMAX);
      tb = rate_bin(tbl_tkn[i], ex);
      rb = rate_bin(tbl_trn[i], ex);
      c = rb * N_BINS + tb;
      hyb_cnt[c] = sat(hyb_cnt[c], 1, HMAX);
      hyb_ex[c] = sat(hyb_ex[c], ex, VMAX);
      tkn_hist[tb] = sat(tkn_hist[tb], 1, VMAX);
      tkn_hist[N_BINS+tb] = sat(tkn_hist[N_BINS+tb], ex, VMAX);
      trn_hist[rb] = sat(trn_hist[rb], 1, VMAX);
      trn_hist[N_BINS+rb] = sat(trn_hist[N_BINS+rb], ex, VMAX);
      total_ex = sat(total_ex, ex, VMAX);
    end
  endfunction

  function automatic longint histogram_value(logic [2:0] sel, int row, int col);
    if (sel == RSEL_TOTAL) return total_ex;
    if (sel > RSEL_TOTAL || row >= N_BINS) return 0;
    case (sel)
      RSEL_HYB_CNT: return (col >= N_BINS) ? 0 : hyb_cnt[row*N_BINS+col];
      RSEL_HYB_EX:  return (col >= N_BINS) ? 0 : hyb_ex[row*N_BINS+col];
      RSEL_TKN_CNT: return tkn_hist[row];
      RSEL_TRN_CNT: return trn_hist[row];
      RSEL_TKN_EX:  return tkn_hist[N_BINS+row];
      default:      return trn_hist[N_BINS+row];
    endcase
  endfunction

  function automatic brc_res_t predict_result(brc_txn_t t);
    brc_res_t r;
    r.value = '0;
    r.dropped = 1'b0;
    case (t.cmd)
      CMD_EVENT:    r.dropped = apply_event(t.pc, t.taken);
      CMD_CLASSIFY: rebuild_histograms();
      CMD_READ:     r.value = VAL_W'(histogram_value(t.sel, t.row, t.col));
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_txn(brc_txn_t t);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    evt_if.valid         <= 1'b1;
    evt_if.command       <= t.cmd;
    evt_if.branch_pc     <= t.pc;
    evt_if.outcome_taken <= t.taken;
    evt_if.read_select   <= t.sel;
    evt_if.row_bin       <= t.row;
    evt_if.col_bin       <= t.col;
    do @(posedge clk_i); while (!evt_if.ready);
    expected_q.push_back(predict_result(t));
  endtask

  function automatic brc_txn_t mk(cmd_e c, logic [47:0] pc, bit tk, logic [2:0] sel,
                                  logic [4:0] row, logic [4:0] col);
    brc_txn_t t;
    t.cmd = c;
    t.pc = pc;
    t.taken = tk;
    t.sel = sel;
    t.row = row;
    t.col = col;
    return t;
  endfunction

  task automatic send_event(logic [47:0] pc, bit tk);
    send_txn(mk(CMD_EVENT, pc, tk, 3'($urandom), 5'($urandom), 5'($urandom)));
  endtask

  task automatic send_read(logic [2:0] sel, logic [4:0] row, logic [4:0] col);
    send_txn(mk(CMD_READ, 48'({$urandom, $urandom}), 1'($urandom), sel, row, col));
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic read_sweep();
    for (int s = 0; s <= 7; s++) begin
      send_read(3'(s), 5'($urandom_range(0, 19)), 5'($urandom_range(0, 19)));
    end
  endtask

  task automatic test_directed();
    send_event(48'h0, 1'b1);
    send_event(48'h0, 1'b0);
    send_event(48'h0, 1'b0);
    send_event(48'hFFFF_FFFF_FFFF, 1'b1);
    send_event(48'hFFFF_FFFF_FFFF, 1'b1);
    send_event(48'hAAAA_5555_AAAA, 1'b0);
    send_txn(mk(CMD_NOP, 48'h5555_AAAA_5555, 1'b1, 3'd7, 5'd31, 5'd31));
    send_txn(mk(CMD_CLASSIFY, '0, 1'b0, '0, '0, '0));
    read_sweep();
    send_read(RSEL_HYB_CNT, 5'd19, 5'd19);
    send_read(RSEL_HYB_CNT, 5'd31, 5'd0);
    send_read(RSEL_HYB_EX, 5'd0, 5'd20);
    send_read(RSEL_TKN_CNT, 5'd20, 5'd0);
    send_read(3'd7, 5'd0, 5'd0);
    send_txn(mk(CMD_CLASSIFY, '0, 1'b0, '0, '0, '0));
    send_read(RSEL_TOTAL, '0, '0);
    evt_if.valid <= 1'b0;
  endtask

  task automatic test_random_mix();
    brc_txn_t t;
    int k;
    foreach (pc_pool[i]) pc_pool[i] = 48'({$urandom, $urandom});
    for (int n = 0; n < 340; n++) begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        send_event(($urandom_range(0, 4) == 0) ? 48'({$urandom, $urandom})
                                               : pc_pool[$urandom_range(0, 15)],
                   1'($urandom));
      end else if (k < 66) begin
        send_txn(mk(CMD_CLASSIFY, 48'({$urandom, $urandom}), 1'($urandom), 3'($urandom),
                    5'($urandom), 5'($urandom)));
      end else if (k < 94) begin
        send_read(3'($urandom_range(0, 7)),
                  5'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 19)),
                  5'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 19)));
      end else begin
        t = mk(CMD_NOP, 48'({$urandom, $urandom}), 1'($urandom), 3'($urandom),
               5'($urandom), 5'($urandom));
        send_txn(t);
      end
    end
    send_txn(mk(CMD_CLASSIFY, '0, 1'b0, '0, '0, '0));
    evt_if.valid <= 1'b0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      begin
        for (int n = 0; n < 12; n++) begin
          send_read(3'($urandom_range(0, 6)), 5'($urandom_range(0, 19)),
                    5'($urandom_range(0, 19)));
        end
        evt_if.valid <= 1'b0;
      end
    join
    drain();
  endtask

  task automatic test_final_burst();
    gaps_on = 1'b0;
    stall_en = 1'b0;
    for (int n = 0; n < 40; n++) begin
      if (n % 2 == 0) begin
        send_event(pc_pool[$urandom_range(0, 15)], 1'($urandom));
      end else begin
        send_read(3'($urandom_range(0, 6)), 5'($urandom_range(0, 19)),
                  5'($urandom_range(0, 19)));
      end
    end
    send_txn(mk(CMD_CLASSIFY, '0, 1'b0, '0, '0, '0));
    read_sweep();
    evt_if.valid <= 1'b0;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    brc_res_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected transaction value=%h dropped=%b",
                                  res_if.read_value, res_if.dropped);
      end else begin
        e = expected_q.pop_front();
        if (res_if.read_value !== e.value || res_if.dropped !== e.dropped) begin
          n_err++;
          if (n_err <= 10) $display("mismatch exp value=%h dropped=%b got value=%h dropped=%b",
                                    e.value, e.dropped, res_if.read_value, res_if.dropped);
        end
      end
    end
  end

  // Receiver stalls
  initial begin
    int burst;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        res_if.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        res_if.ready <= 1'b0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 4);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    evt_if.valid         <= 1'b0;
    evt_if.command       <= CMD_NOP;
    evt_if.branch_pc     <= '0;
    evt_if.outcome_taken <= 1'b0;
    evt_if.read_select   <= '0;
    evt_if.row_bin       <= '0;
    evt_if.col_bin       <= '0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    rebuild_histograms();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain();
    test_random_mix();
    drain();
    test_backpressure();
    test_final_burst();
    drain();
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
